[rtl/core/hpool_pkg.sv]
package hpool_pkg;

    localparam int HANDLE_W  = 10;
    localparam int COUNT_W   = HANDLE_W + 1;
    localparam int POOL_SIZE = 1 << HANDLE_W;

    localparam logic [1:0] OP_ALLOC       = 2'd0;
    localparam logic [1:0] OP_FREE_POS    = 2'd1;
    localparam logic [1:0] OP_FREE_HANDLE = 2'd2;

    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_FULL        = 2'd1;
    localparam logic [1:0] STAT_POS_DEAD    = 2'd2;
    localparam logic [1:0] STAT_HANDLE_DEAD = 2'd3;

    typedef struct packed {
        logic [1:0]          operation;
        logic [HANDLE_W-1:0] slot_position;
        logic [HANDLE_W-1:0] target_handle;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] result_handle;
        logic [HANDLE_W-1:0] freed_position;
        logic [COUNT_W-1:0]  live_count;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic read_last;
        logic swap_first;
        logic swap_second;
        logic finish_simple;
        logic finish_free;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic free_ok;
        logic out_free;
    } dp_stat_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SWAP_A,
        S_SWAP_B
    } state_t;

endpackage

[rtl/core/hpool_ram.sv]
module hpool_ram #(
    parameter int WIDTH = hpool_pkg::HANDLE_W,
    parameter int DEPTH = hpool_pkg::POOL_SIZE
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/hpool_ctrl.sv]
module hpool_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hpool_pkg::dp_stat_t stat,
    output hpool_pkg::dp_cmd_t  cmd
);

    hpool_pkg::state_t state_reg;
    hpool_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hpool_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hpool_pkg::S_CLEAR: begin
                if (stat.clear_done) begin
                    state_next = hpool_pkg::S_IDLE;
                end
            end
            hpool_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = hpool_pkg::S_CHECK;
                end
            end
            hpool_pkg::S_CHECK: begin
                if (stat.free_ok) begin
                    state_next = hpool_pkg::S_SWAP_A;
                end else if (stat.out_free) begin
                    state_next = hpool_pkg::S_IDLE;
                end
            end
            hpool_pkg::S_SWAP_A: begin
                state_next = hpool_pkg::S_SWAP_B;
            end
            hpool_pkg::S_SWAP_B: begin
                if (stat.out_free) begin
                    state_next = hpool_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = hpool_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            hpool_pkg::S_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            hpool_pkg::S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            hpool_pkg::S_CHECK: begin
                cmd.read_last     = stat.free_ok;
                cmd.finish_simple = !stat.free_ok && stat.out_free;
            end
            hpool_pkg::S_SWAP_A: begin
                cmd.swap_first = 1'b1;
            end
            hpool_pkg::S_SWAP_B: begin
                cmd.swap_second = 1'b1;
                cmd.finish_free = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.swap_first |=> cmd.swap_second)
        else $error("swap did not continue to its second write");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.swap_second |-> $past(cmd.swap_first) || $past(cmd.swap_second))
        else $error("second swap write without a first");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish_simple || cmd.finish_free) |-> stat.out_free)
        else $error("result loaded while output register is occupied");
`endif

endmodule

[rtl/core/hpool_dp.sv]
module hpool_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hpool_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hpool_pkg::out_item_t m_data,
    input  hpool_pkg::dp_cmd_t   cmd,
    output hpool_pkg::dp_stat_t  stat
);

    localparam int HW = hpool_pkg::HANDLE_W;
    localparam int CW = hpool_pkg::COUNT_W;

    hpool_pkg::in_item_t  in_reg;
    hpool_pkg::out_item_t out_reg;
    hpool_pkg::out_item_t out_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [HW-1:0]        clr_reg;
    logic [HW-1:0]        p_reg;
    logic [HW-1:0]        h_reg;

    logic          slot_we;
    logic [HW-1:0] slot_waddr;
    logic [HW-1:0] slot_wdata;
    logic          slot_re;
    logic [HW-1:0] slot_raddr;
    logic [HW-1:0] slot_rdata;
    logic          inv_we;
    logic [HW-1:0] inv_waddr;
    logic [HW-1:0] inv_wdata;
    logic [HW-1:0] inv_rdata;

    logic [CW-1:0] count_dec;
    logic [CW-1:0] count_inc;
    logic [HW-1:0] last_pos;
    logic          alloc_ok;
    logic          pos_live;
    logic          handle_live;
    logic          is_free_pos;
    logic [HW-1:0] victim_pos;
    logic [HW-1:0] victim_handle;

    assign count_dec   = count_reg - CW'(1);
    assign count_inc   = count_reg + CW'(1);
    assign last_pos    = count_dec[HW-1:0];
    assign alloc_ok    = count_reg < CW'(hpool_pkg::POOL_SIZE);
    assign pos_live    = {1'b0, in_reg.slot_position} < count_reg;
    assign handle_live = {1'b0, inv_rdata} < count_reg;
    assign is_free_pos = in_reg.operation == hpool_pkg::OP_FREE_POS;

    assign victim_pos    = is_free_pos ? in_reg.slot_position : inv_rdata;
    assign victim_handle = is_free_pos ? slot_rdata : in_reg.target_handle;

    assign stat.clear_done = clr_reg == HW'(hpool_pkg::POOL_SIZE - 1);
    assign stat.free_ok    = (is_free_pos && pos_live)
                          || (in_reg.operation == hpool_pkg::OP_FREE_HANDLE && handle_live);
    assign stat.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        slot_re    = 1'b0;
        slot_raddr = last_pos;
        if (cmd.accept) begin
            slot_re    = 1'b1;
            slot_raddr = (s_data.operation == hpool_pkg::OP_ALLOC)
                       ? count_reg[HW-1:0] : s_data.slot_position;
        end else if (cmd.read_last) begin
            slot_re = 1'b1;
        end
    end

    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = clr_reg;
        slot_wdata = clr_reg;
        inv_we     = 1'b0;
        inv_waddr  = clr_reg;
        inv_wdata  = clr_reg;
        if (cmd.clear_step) begin
            slot_we = 1'b1;
            inv_we  = 1'b1;
        end else if (cmd.swap_first) begin
            slot_we    = 1'b1;
            slot_waddr = p_reg;
            slot_wdata = slot_rdata;
            inv_we     = 1'b1;
            inv_waddr  = slot_rdata;
            inv_wdata  = p_reg;
        end else if (cmd.swap_second) begin
            slot_we    = 1'b1;
            slot_waddr = last_pos;
            slot_wdata = h_reg;
            inv_we     = 1'b1;
            inv_waddr  = h_reg;
            inv_wdata  = last_pos;
        end
    end

    hpool_ram #(
        .WIDTH(HW),
        .DEPTH(hpool_pkg::POOL_SIZE)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (slot_we),
        .waddr(slot_waddr),
        .wdata(slot_wdata),
        .re   (slot_re),
        .raddr(slot_raddr),
        .rdata(slot_rdata)
    );

    hpool_ram #(
        .WIDTH(HW),
        .DEPTH(hpool_pkg::POOL_SIZE)
    ) u_inv_ram (
        .aclk (aclk),
        .we   (inv_we),
        .waddr(inv_waddr),
        .wdata(inv_wdata),
        .re   (cmd.accept),
        .raddr(s_data.target_handle),
        .rdata(inv_rdata)
    );

    always_comb begin
        out_next   = out_reg;
        count_next = count_reg;
        if (cmd.finish_simple) begin
            out_next.status         = hpool_pkg::STAT_OK;
            out_next.result_handle  = '0;
            out_next.freed_position = '0;
            out_next.live_count     = count_reg;
            case (in_reg.operation)
                hpool_pkg::OP_ALLOC: begin
                    if (alloc_ok) begin
                        out_next.result_handle = slot_rdata;
                        out_next.live_count    = count_inc;
                        count_next             = count_inc;
                    end else begin
                        out_next.status = hpool_pkg::STAT_FULL;
                    end
                end
                hpool_pkg::OP_FREE_POS: begin
                    out_next.status = hpool_pkg::STAT_POS_DEAD;
                end
                hpool_pkg::OP_FREE_HANDLE: begin
                    out_next.status = hpool_pkg::STAT_HANDLE_DEAD;
                end
                default: begin
                    out_next.status = hpool_pkg::STAT_OK;
                end
            endcase
        end else if (cmd.finish_free) begin
            out_next.status         = hpool_pkg::STAT_OK;
            out_next.result_handle  = h_reg;
            out_next.freed_position = p_reg;
            out_next.live_count     = count_dec;
            count_next              = count_dec;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish_simple || cmd.finish_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            clr_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            if (cmd.clear_step) begin
                clr_reg <= clr_reg + HW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (cmd.accept) begin
            in_reg <= s_data;
        end
        if (cmd.read_last) begin
            p_reg <= victim_pos;
            h_reg <= victim_handle;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish_free |-> count_reg != '0)
        else $error("free completed with an empty pool");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish_free |=> count_reg == $past(count_dec))
        else $error("live count did not drop after a free");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(hpool_pkg::POOL_SIZE) && !(cmd.accept && cmd.clear_step))
        else $error("live count out of range or accept during clear");
`endif

endmodule

[rtl/core/handle_pool_swap_remove_allocator_top.sv]
// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_data  (operation, slot_position, target_handle)
// m_       out        m_valid / m_ready   m_data  (status, result_handle, freed_position,
//                                                  live_count)
//
// After reset the block writes the identity permutation into the position table and its
// inverse, with s_ready low.
// An allocate or a rejected operation finishes in the check step; a successful free goes on
// through S_SWAP_A and S_SWAP_B, as it writes each table twice on its single write port.
// A finished result sits in the output register while the next transaction is taken.
// A full output register holds the controller in its last step until m_ready frees it.
module handle_pool_swap_remove_allocator_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hpool_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hpool_pkg::out_item_t m_data
);

    hpool_pkg::dp_cmd_t  cmd;
    hpool_pkg::dp_stat_t stat;

    hpool_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    hpool_dp u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule

[tb/sv/hpool_checker.sv]
module hpool_checker
    import hpool_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        mismatch_count,
    output int        pending_count,
    output int        checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [HANDLE_W-1:0] slot_map [POOL_SIZE];
    logic [COUNT_W-1:0]  live;
    out_item_t           owed_replies [$];
    out_item_t           oldest;
    int                  errors;
    int                  checked;

    function automatic out_item_t apply_pool_op(input in_item_t req);
        out_item_t           rsp;
        logic                hit;
        logic [HANDLE_W-1:0] pos;
        logic [HANDLE_W-1:0] taken;
        logic [HANDLE_W-1:0] last;
        int                  i;
        rsp = '0;
        hit = 1'b0;
        pos = '0;
        case (req.operation)
            OP_ALLOC: begin
                if (live < POOL_SIZE) begin
                    rsp.result_handle = slot_map[live[HANDLE_W-1:0]];
                    live = live + 1'b1;
                end else begin
                    rsp.status = STAT_FULL;
                end
            end
            OP_FREE_POS: begin
                if (req.slot_position < live) begin
                    hit = 1'b1;
                    pos = req.slot_position;
                end else begin
                    rsp.status = STAT_POS_DEAD;
                end
            end
            OP_FREE_HANDLE: begin
                // The search runs from the top of the live region downward.
                i = int'(live);
                while (i > 0 && !hit) begin
                    i--;
                    if (slot_map[i] == req.target_handle) begin
                        hit = 1'b1;
                        pos = HANDLE_W'(i);
                    end
                end
                if (!hit) begin
                    rsp.status = STAT_HANDLE_DEAD;
                end
            end
            default: begin
            end
        endcase
        if (hit) begin
            last = HANDLE_W'(live - 1'b1);
            taken = slot_map[pos];
            slot_map[pos] = slot_map[last];
            slot_map[last] = taken;
            live = live - 1'b1;
            rsp.result_handle = taken;
            rsp.freed_position = pos;
        end
        rsp.live_count = live;
        return rsp;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < POOL_SIZE; k++) begin
                slot_map[k] = HANDLE_W'(k);
            end
            live = '0;
            owed_replies.delete();
            errors = 0;
            checked = 0;
        end else begin
            if (s_valid && s_ready) begin
                owed_replies.push_back(apply_pool_op(s_data));
            end
            if (m_valid && m_ready) begin
                if (owed_replies.size() == 0) begin
                    $error("result transaction with no request outstanding: %p", m_data);
                    errors++;
                end else begin
                    oldest = owed_replies.pop_front();
                    compare_field("status", 32'(oldest.status), 32'(m_data.status));
                    compare_field("result_handle", 32'(oldest.result_handle),
                                  32'(m_data.result_handle));
                    compare_field("freed_position", 32'(oldest.freed_position),
                                  32'(m_data.freed_position));
                    compare_field("live_count", 32'(oldest.live_count),
                                  32'(m_data.live_count));
                    checked++;
                end
            end
        end
        mismatch_count <= errors;
        pending_count <= owed_replies.size();
        checked_count <= checked;
    end

endmodule

[tb/sv/tb.sv]
module tb;
    import hpool_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         DRAIN_CYCLES   = 16;
    localparam int         SEGMENT_ITEMS  = 20;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int src_idle_pct;
    int snk_idle_pct;
    int op_sent [4];

    always #1 aclk = ~aclk;

    handle_pool_swap_remove_allocator_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    hpool_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    task automatic send(input logic [1:0] op, input logic [HANDLE_W-1:0] pos,
                        input logic [HANDLE_W-1:0] hnd);
        in_item_t req;
        req.operation = op;
        req.slot_position = pos;
        req.target_handle = hnd;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        op_sent[op]++;
    endtask

    task automatic run_random(input int count, input int alloc_pct);
        int          pick;
        int          free_pos_pct;
        logic [1:0]  op;
        free_pos_pct = (96 - alloc_pct) / 2;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct) begin
                op = OP_ALLOC;
            end else if (pick < alloc_pct + free_pos_pct) begin
                op = OP_FREE_POS;
            end else if (pick < 96) begin
                op = OP_FREE_HANDLE;
            end else begin
                op = OP_UNUSED;
            end
            send(op, HANDLE_W'($urandom), HANDLE_W'($urandom));
        end
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[handle_pool_swap_remove_allocator_top] ERROR");
        $finish;
    end

    initial begin : stimulus
        for (int k = 0; k < 4; k++) begin
            op_sent[k] = 0;
        end
        src_idle_pct = 16;
        snk_idle_pct = 86;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty pool: rejects, the unused code, and a round trip through one handle.
        send(OP_ALLOC, '1, '1);
        send(OP_UNUSED, '1, '1);
        send(OP_FREE_POS, '1, '0);
        send(OP_FREE_POS, 10'd1, '0);
        send(OP_FREE_HANDLE, '0, '1);
        send(OP_FREE_HANDLE, '1, '0);
        send(OP_FREE_HANDLE, '0, '0);
        send(OP_FREE_POS, '0, '1);

        // A few live handles: frees from the middle and from the last live position.
        repeat (4) send(OP_ALLOC, '0, '0);
        send(OP_FREE_POS, 10'd1, '0);
        send(OP_FREE_HANDLE, '0, 10'd3);
        send(OP_FREE_HANDLE, '0, 10'd1);
        send(OP_FREE_POS, 10'd1, '0);

        // Fill the pool until it reports full, then work at the top end.
        repeat (POOL_SIZE) send(OP_ALLOC, HANDLE_W'($urandom), HANDLE_W'($urandom));
        send(OP_ALLOC, '0, '0);
        send(OP_FREE_POS, '1, '0);
        send(OP_ALLOC, '0, '0);
        send(OP_FREE_POS, '0, '1);
        send(OP_FREE_HANDLE, '1, '1);
        send(OP_FREE_HANDLE, '1, '0);
        send(OP_UNUSED, '0, '0);
        send(OP_ALLOC, '1, '1);

        run_random(SEGMENT_ITEMS, 20);
        src_idle_pct = 86;
        snk_idle_pct = 16;
        run_random(SEGMENT_ITEMS, 35);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(SEGMENT_ITEMS, 75);
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending_count != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d allocates, %0d position frees, %0d handle frees, %0d unused codes.",
                 op_sent[OP_ALLOC], op_sent[OP_FREE_POS], op_sent[OP_FREE_HANDLE],
                 op_sent[OP_UNUSED]);
        $display("Checked %0d results, full and empty pool, three stall mixes; %0d mismatches.",
                 checked_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[handle_pool_swap_remove_allocator_top] OK");
        end else begin
            $display("[handle_pool_swap_remove_allocator_top] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/hpool_pkg.sv
rtl/core/hpool_ram.sv
rtl/core/hpool_ctrl.sv
rtl/core/hpool_dp.sv
rtl/core/handle_pool_swap_remove_allocator_top.sv
tb/sv/hpool_checker.sv
tb/sv/tb.sv
